// ===== sv/sdke_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdke_pkg
// Shared types, constants and helpers of the sample delta/keyframe encoder.
// ----------------------------------------------------------------------------
package sdke_pkg;

    localparam int MAX_CHANNELS  = 4;
    localparam int NUM_CHANNELS  = 4;
    localparam int CH_W          = 16;
    localparam int WORD_W        = MAX_CHANNELS * CH_W;
    localparam int TIME_W        = 32;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [CH_W-1:0] RESET_STEP = 16'd1000;
    localparam logic [CH_W-1:0] RESET_GAP  = 16'd60000;

    typedef enum logic [1:0] {
        REG_MAX_VOLTAGE_STEP = 2'd0,
        REG_MAX_CURRENT_STEP = 2'd1,
        REG_MAX_POWER_STEP   = 2'd2,
        REG_MAX_GAP_MS       = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] volt_step;
        logic [CH_W-1:0] curr_step;
        logic [CH_W-1:0] pwr_step;
    } step_cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] volt;
        logic [CH_W-1:0] curr;
        logic [CH_W-1:0] pwr;
        logic [CH_W-1:0] dvolt;
        logic [CH_W-1:0] dcurr;
        logic [CH_W-1:0] dpwr;
        logic            exceed;
    } lane_res_t;

    typedef struct packed {
        logic              is_base;
        logic [TIME_W-1:0] time_value;
        logic [WORD_W-1:0] voltage_word;
        logic [WORD_W-1:0] current_word;
        logic [WORD_W-1:0] power_word;
    } entry_t;

    // Magnitude of a wrapped 16-bit difference read as signed: 0..32768.
    function automatic logic [CH_W:0] diff_magnitude(input logic [CH_W-1:0] d);
        logic [CH_W:0] ext;
        ext = {1'b0, d};
        if (d[CH_W-1])
            return (17'h10000 - ext);
        return ext;
    endfunction

endpackage

// ===== sv/sdke_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdke_lane
// One channel: holds the previous readings, forms the wrapped differences
// and flags a step beyond any of the three thresholds.
// ----------------------------------------------------------------------------
module sdke_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [sdke_pkg::CH_W-1:0]     volt,
    input  logic [sdke_pkg::CH_W-1:0]     curr,
    input  logic [sdke_pkg::CH_W-1:0]     pwr,
    input  sdke_pkg::step_cfg_t           step,
    output sdke_pkg::lane_res_t           res
);

    logic [sdke_pkg::CH_W-1:0] prev_volt_reg, prev_volt_next;
    logic [sdke_pkg::CH_W-1:0] prev_curr_reg, prev_curr_next;
    logic [sdke_pkg::CH_W-1:0] prev_pwr_reg,  prev_pwr_next;
    logic [sdke_pkg::CH_W-1:0] dvolt, dcurr, dpwr;

    assign dvolt = volt - prev_volt_reg;
    assign dcurr = curr - prev_curr_reg;
    assign dpwr  = pwr  - prev_pwr_reg;

    always_comb
    begin
        res.volt   = volt;
        res.curr   = curr;
        res.pwr    = pwr;
        res.dvolt  = dvolt;
        res.dcurr  = dcurr;
        res.dpwr   = dpwr;
        res.exceed = (sdke_pkg::diff_magnitude(dvolt) > {1'b0, step.volt_step}) ||
                     (sdke_pkg::diff_magnitude(dcurr) > {1'b0, step.curr_step}) ||
                     (sdke_pkg::diff_magnitude(dpwr)  > {1'b0, step.pwr_step});
    end

    // Previous readings follow every transfer, base or delta.
    assign prev_volt_next = load ? volt : prev_volt_reg;
    assign prev_curr_next = load ? curr : prev_curr_reg;
    assign prev_pwr_next  = load ? pwr  : prev_pwr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_volt_reg <= '0;
            prev_curr_reg <= '0;
            prev_pwr_reg  <= '0;
        end
        else
        begin
            prev_volt_reg <= prev_volt_next;
            prev_curr_reg <= prev_curr_next;
            prev_pwr_reg  <= prev_pwr_next;
        end
    end

endmodule

// ===== sv/sdke_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdke_merge
// Combines the lane flags with the time gap check and builds the entry:
// full values for a base entry, differences for a delta entry.
// ----------------------------------------------------------------------------
module sdke_merge (
    input  sdke_pkg::lane_res_t                 lanes [sdke_pkg::MAX_CHANNELS],
    input  logic                                have_ref,
    input  logic [sdke_pkg::TIME_W-1:0]         now,
    input  logic [sdke_pkg::TIME_W-1:0]         prev_time,
    input  logic [sdke_pkg::CH_W-1:0]           max_gap,
    output sdke_pkg::entry_t                    entry
);

    localparam int CH_W = sdke_pkg::CH_W;

    logic [sdke_pkg::TIME_W-1:0] gap;
    logic [sdke_pkg::WORD_W-1:0] vw, cw, pw, dvw, dcw, dpw;
    logic                        exceed;
    logic                        base;

    assign gap = now - prev_time;

    always_comb
    begin
        exceed = 1'b0;
        vw  = '0;
        cw  = '0;
        pw  = '0;
        dvw = '0;
        dcw = '0;
        dpw = '0;
        for (int c = 0; c < sdke_pkg::MAX_CHANNELS; c++)
        begin
            exceed              = exceed | lanes[c].exceed;
            vw[c*CH_W +: CH_W]  = lanes[c].volt;
            cw[c*CH_W +: CH_W]  = lanes[c].curr;
            pw[c*CH_W +: CH_W]  = lanes[c].pwr;
            dvw[c*CH_W +: CH_W] = lanes[c].dvolt;
            dcw[c*CH_W +: CH_W] = lanes[c].dcurr;
            dpw[c*CH_W +: CH_W] = lanes[c].dpwr;
        end
    end

    assign base = !have_ref || exceed ||
                  (gap > {{(sdke_pkg::TIME_W-CH_W){1'b0}}, max_gap});

    always_comb
    begin
        entry.is_base      = base;
        entry.time_value   = base ? now : gap;
        entry.voltage_word = base ? vw  : dvw;
        entry.current_word = base ? cw  : dcw;
        entry.power_word   = base ? pw  : dpw;
    end

endmodule

// ===== sv/sample_delta_keyframe_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_delta_keyframe_encoder_core
// Top level of the sample delta/keyframe encoder: lanes, merge, output stage
// and APB register file.
// ----------------------------------------------------------------------------
// The encoder takes one snapshot per clock while in_ready is high and
// returns exactly one entry per snapshot, in order. Each channel has its own
// lane with its difference and threshold logic, so all channels are handled
// in the same cycle; the time gap check runs beside them. An output register
// with a one-entry skid stage lets a new snapshot in while an entry waits on
// a stalled consumer; input ready depends only on the skid stage, so it
// drops after a snapshot is taken while an entry waits on a stalled consumer.
// Channels at or above NUM_CHANNELS read as zero. Thresholds and the maximum
// gap are written through the APB port at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module sample_delta_keyframe_encoder_core #(
    parameter int NUM_CHANNELS = sdke_pkg::NUM_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // snapshot channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sdke_pkg::WORD_W-1:0]       voltages,
    input  logic [sdke_pkg::WORD_W-1:0]       currents,
    input  logic [sdke_pkg::WORD_W-1:0]       powers,
    input  logic [sdke_pkg::TIME_W-1:0]       sample_time,
    // entry channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              is_base,
    output logic [sdke_pkg::TIME_W-1:0]       time_value,
    output logic [sdke_pkg::WORD_W-1:0]       voltage_word,
    output logic [sdke_pkg::WORD_W-1:0]       current_word,
    output logic [sdke_pkg::WORD_W-1:0]       power_word,
    // APB register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdke_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sdke_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sdke_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CH_W = sdke_pkg::CH_W;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [CH_W-1:0]      volt_step_reg, volt_step_next;
    logic [CH_W-1:0]      curr_step_reg, curr_step_next;
    logic [CH_W-1:0]      pwr_step_reg,  pwr_step_next;
    logic [CH_W-1:0]      max_gap_reg,   max_gap_next;
    logic                 cfg_write;
    sdke_pkg::reg_index_t reg_sel;
    sdke_pkg::step_cfg_t  step;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = sdke_pkg::reg_index_t'(paddr[3:2]);

    always_comb
    begin
        volt_step_next = volt_step_reg;
        curr_step_next = curr_step_reg;
        pwr_step_next  = pwr_step_reg;
        max_gap_next   = max_gap_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                sdke_pkg::REG_MAX_VOLTAGE_STEP: volt_step_next = pwdata[CH_W-1:0];
                sdke_pkg::REG_MAX_CURRENT_STEP: curr_step_next = pwdata[CH_W-1:0];
                sdke_pkg::REG_MAX_POWER_STEP:   pwr_step_next  = pwdata[CH_W-1:0];
                sdke_pkg::REG_MAX_GAP_MS:       max_gap_next   = pwdata[CH_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            sdke_pkg::REG_MAX_VOLTAGE_STEP:
                prdata = {{(sdke_pkg::APB_DATA_W-CH_W){1'b0}}, volt_step_reg};
            sdke_pkg::REG_MAX_CURRENT_STEP:
                prdata = {{(sdke_pkg::APB_DATA_W-CH_W){1'b0}}, curr_step_reg};
            sdke_pkg::REG_MAX_POWER_STEP:
                prdata = {{(sdke_pkg::APB_DATA_W-CH_W){1'b0}}, pwr_step_reg};
            sdke_pkg::REG_MAX_GAP_MS:
                prdata = {{(sdke_pkg::APB_DATA_W-CH_W){1'b0}}, max_gap_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_step_reg <= sdke_pkg::RESET_STEP;
            curr_step_reg <= sdke_pkg::RESET_STEP;
            pwr_step_reg  <= sdke_pkg::RESET_STEP;
            max_gap_reg   <= sdke_pkg::RESET_GAP;
        end
        else
        begin
            volt_step_reg <= volt_step_next;
            curr_step_reg <= curr_step_next;
            pwr_step_reg  <= pwr_step_next;
            max_gap_reg   <= max_gap_next;
        end
    end

    assign step.volt_step = volt_step_reg;
    assign step.curr_step = curr_step_reg;
    assign step.pwr_step  = pwr_step_reg;

    // ------------------------------------------------------------------
    // Lanes and merge
    // ------------------------------------------------------------------
    logic                          in_fire;
    sdke_pkg::lane_res_t           lane_res [sdke_pkg::MAX_CHANNELS];
    sdke_pkg::entry_t              entry;
    logic                          have_ref_reg, have_ref_next;
    logic [sdke_pkg::TIME_W-1:0]   prev_time_reg, prev_time_next;

    assign in_fire = in_valid && in_ready;

    for (genvar c = 0; c < sdke_pkg::MAX_CHANNELS; c++)
    begin : g_lane
        if (c < NUM_CHANNELS)
        begin : g_on
            sdke_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .load  (in_fire),
                .volt  (voltages[c*CH_W +: CH_W]),
                .curr  (currents[c*CH_W +: CH_W]),
                .pwr   (powers[c*CH_W +: CH_W]),
                .step  (step),
                .res   (lane_res[c])
            );
        end
        else
        begin : g_off
            assign lane_res[c] = '0;
        end
    end

    sdke_merge u_merge (
        .lanes     (lane_res),
        .have_ref  (have_ref_reg),
        .now       (sample_time),
        .prev_time (prev_time_reg),
        .max_gap   (max_gap_reg),
        .entry     (entry)
    );

    assign have_ref_next  = have_ref_reg | in_fire;
    assign prev_time_next = in_fire ? sample_time : prev_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_ref_reg  <= 1'b0;
            prev_time_reg <= '0;
        end
        else
        begin
            have_ref_reg  <= have_ref_next;
            prev_time_reg <= prev_time_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    sdke_pkg::entry_t out_reg,  out_next;
    sdke_pkg::entry_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             out_free;

    assign in_ready = !skid_valid_reg;
    assign out_free = out_ready || !out_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            // drain the skid entry first; a new transfer only comes with it empty
            out_valid_next  = skid_valid_reg || in_fire;
            out_next        = skid_valid_reg ? skid_reg : entry;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            // hold the new entry while the consumer stalls
            skid_valid_next = 1'b1;
            skid_next       = entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign is_base      = out_reg.is_base;
    assign time_value   = out_reg.time_value;
    assign voltage_word = out_reg.voltage_word;
    assign current_word = out_reg.current_word;
    assign power_word   = out_reg.power_word;

endmodule

// ===== sv/sdke_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdke_checker
// Port-level checks of the sample delta/keyframe encoder, bound to the top.
// ----------------------------------------------------------------------------
module sdke_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          is_base,
    input logic [sdke_pkg::TIME_W-1:0]   time_value,
    input logic [sdke_pkg::WORD_W-1:0]   voltage_word,
    input logic [sdke_pkg::WORD_W-1:0]   current_word,
    input logic [sdke_pkg::WORD_W-1:0]   power_word
);

    logic seen_out_reg, seen_out_next;

    assign seen_out_next = seen_out_reg | (out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_out_reg <= 1'b0;
        else
            seen_out_reg <= seen_out_next;
    end

    // The first entry after reset has no reference and must be a base entry.
    a_first_is_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !seen_out_reg) |-> is_base)
        else $error("first entry after reset is not a base entry");

    // After every transfer in, an entry is valid at the output in the next cycle.
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted snapshot produced no entry");

    // Back pressure only while an entry is pending.
    a_ready_low_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // With the output empty the skid stage is empty, so ready follows.
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> in_ready)
        else $error("input not ready after empty output");

    // A stalled entry holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(is_base) &&
        $stable(time_value) && $stable(voltage_word) &&
        $stable(current_word) && $stable(power_word)))
        else $error("stalled entry changed");

endmodule

bind sample_delta_keyframe_encoder_core sdke_checker u_sdke_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_base      (is_base),
    .time_value   (time_value),
    .voltage_word (voltage_word),
    .current_word (current_word),
    .power_word   (power_word)
);
